// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, with no reset qualification.
`define LSRDG_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check on every clock edge outside of reset.
`define LSRDG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: rtl/lsrdg_pkg.sv
// Shared types, codes and arithmetic helpers of the lidar ray direction generator.
// No dependencies.
package lsrdg_pkg;

	typedef struct packed {
		logic [1:0]         func;
		logic [5:0]         entry_index;
		logic signed [15:0] elevation_value;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [5:0]         row_number;
		logic [11:0]        column_number;
		logic               scan_end;
	} out_item_t;

	// Ray request handed from the front to the back end.
	typedef struct packed {
		logic signed [15:0] elevation;
		logic [5:0]         row_number;
		logic [11:0]        column_number;
		logic               scan_end;
	} ray_tag_t;

	typedef struct packed {
		logic signed [25:0] z;
		logic               flip;
	} fold_t;

	localparam logic [1:0] FUNC_WRITE   = 2'd0;
	localparam logic [1:0] FUNC_RAY     = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_AZ_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AZ_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 3'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = 3;

	localparam int TURN = 92160;
	localparam logic signed [17:0] TURN_S         = 18'sd92160;
	localparam logic signed [17:0] HALF_TURN_S    = 18'sd46080;
	localparam logic signed [17:0] QUARTER_TURN_S = 18'sd23040;
	localparam logic signed [31:0] CORDIC_GAIN    = 32'sd652032875;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [22:0] atan_lut(input logic [4:0] i);
		logic signed [22:0] v;
		begin
			unique case (i)
				5'd0:  v = 23'sd2949120;
				5'd1:  v = 23'sd1740967;
				5'd2:  v = 23'sd919879;
				5'd3:  v = 23'sd466945;
				5'd4:  v = 23'sd234379;
				5'd5:  v = 23'sd117304;
				5'd6:  v = 23'sd58666;
				5'd7:  v = 23'sd29335;
				5'd8:  v = 23'sd14668;
				5'd9:  v = 23'sd7334;
				5'd10: v = 23'sd3667;
				5'd11: v = 23'sd1833;
				5'd12: v = 23'sd917;
				5'd13: v = 23'sd458;
				5'd14: v = 23'sd229;
				5'd15: v = 23'sd115;
				5'd16: v = 23'sd57;
				5'd17: v = 23'sd29;
				5'd18: v = 23'sd14;
				5'd19: v = 23'sd7;
				5'd20: v = 23'sd4;
				5'd21: v = 23'sd2;
				5'd22: v = 23'sd1;
				default: v = 23'sd0;
			endcase
			atan_lut = v;
		end
	endfunction

	// Fold an angle in [0, 360) degrees into [-90, 90], scaled to 1/65536 degree.
	function automatic fold_t fold_angle(input logic [16:0] a);
		logic signed [17:0] s;
		logic               flip;
		begin
			s = signed'({1'b0, a});
			flip = 1'b0;
			if (s > HALF_TURN_S)
				s = s - TURN_S;
			if (s > QUARTER_TURN_S) begin
				s = s - HALF_TURN_S;
				flip = 1'b1;
			end else if (s < -QUARTER_TURN_S) begin
				s = s + HALF_TURN_S;
				flip = 1'b1;
			end
			fold_angle.z = signed'({s, 8'h00});
			fold_angle.flip = flip;
		end
	endfunction

	function automatic logic signed [15:0] sat_q15(input logic signed [63:0] t);
		begin
			if (t > 64'sd32767)
				sat_q15 = 16'sd32767;
			else if (t < -64'sd32767)
				sat_q15 = -16'sd32767;
			else
				sat_q15 = t[15:0];
		end
	endfunction

	// Q60 product to Q1.15, round half up
	function automatic logic signed [15:0] round_q45(input logic signed [63:0] p);
		logic signed [63:0] t;
		begin
			t = (p + (64'sd1 <<< 44)) >>> 45;
			round_q45 = sat_q15(t);
		end
	endfunction

	// Q2.30 value to Q1.15, round half up
	function automatic logic signed [15:0] round_q15(input logic signed [31:0] v);
		logic signed [63:0] t;
		begin
			t = (64'(v) + 64'sd16384) >>> 15;
			round_q15 = sat_q15(t);
		end
	endfunction

endpackage

// File: rtl/lidar_scan_ray_direction_generator.sv
// Top level of the lidar scan ray direction generator.
// Depends on lsrdg_pkg, lsrdg_front, lsrdg_queue and lsrdg_back.
//
// Usage:
//   Items enter on in_item with push/full. func 0 writes an elevation table row,
//   func 2 restarts the scan at row 0, column 0, func 1 requests the next ray.
//   Only func 1 gives a result; it appears on out_item while empty is low and
//   leaves on pop. Registers are written on cfg_index/cfg_data with
//   cfg_valid/cfg_ready; cfg_ready is always high.
//   From accept to empty going low, a ray passes the read stage, the request
//   queue and the back end states idle, reduce, fold, rotate, multiply and done.
//   The back end sequencer takes a new ray only from idle, once the last result
//   has entered the output register. It reduces the azimuth modulo 360 by a
//   reciprocal multiplication, then does one CORDIC iteration per cycle on
//   both angles at once, sharing the iteration index and arctangent table.
//   Table writes and restarts are taken one per cycle while the request queue
//   has room. A stalled receiver holds the result in the output register; the
//   queue keeps taking items until it fills, then full rises.
//   Reset zeroes the scan position, sets registers to defaults and empties
//   the queue; the elevation table holds no defined value until written.
module lidar_scan_ray_direction_generator #(
	parameter int MAX_ROWS     = 64,
	parameter int MAX_COLUMNS  = 4096,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  lsrdg_pkg::in_item_t             in_item,
	output logic                            empty,
	input  logic                            pop,
	output lsrdg_pkg::out_item_t            out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lsrdg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [17:0]                     cfg_data
);
	localparam int AZW = $clog2(MAX_COLUMNS) + 19;
	localparam int QW  = AZW + $bits(lsrdg_pkg::ray_tag_t);

	logic                           q_push;
	logic [AZW-1:0]                 q_az;
	lsrdg_pkg::ray_tag_t            q_tag;
	logic [lsrdg_pkg::QCNT_W-1:0]   q_count;
	logic                           q_not_empty;
	logic                           q_pop;
	logic [QW-1:0]                  q_head;
	lsrdg_pkg::ray_tag_t            head_tag;

	lsrdg_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLUMNS(MAX_COLUMNS),
		.AZW(AZW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_count(q_count),
		.q_push(q_push),
		.q_az(q_az),
		.q_tag(q_tag)
	);

	lsrdg_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data({q_az, q_tag}),
		.pop(q_pop),
		.pop_data(q_head),
		.not_empty(q_not_empty),
		.count(q_count)
	);

	assign head_tag = q_head[$bits(lsrdg_pkg::ray_tag_t)-1:0];

	lsrdg_back #(
		.AZW(AZW),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(q_not_empty),
		.req_az(q_head[QW-1:$bits(lsrdg_pkg::ray_tag_t)]),
		.req_tag(head_tag),
		.req_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.out_item(out_item)
	);
endmodule

// File: rtl/lsrdg_queue.sv
// Four-entry request queue between the scan front end and the trig back end.
// Depends on lsrdg_pkg.
module lsrdg_queue #(
	parameter int W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 push_data,
	input  logic                         pop,
	output logic [W-1:0]                 pop_data,
	output logic                         not_empty,
	output logic [lsrdg_pkg::QCNT_W-1:0] count
);
	logic [W-1:0] slot_q [lsrdg_pkg::QUEUE_DEPTH];
	logic [1:0]   wr_ptr_q;
	logic [1:0]   rd_ptr_q;
	logic [lsrdg_pkg::QCNT_W-1:0] count_q;

	assign count = count_q;
	assign not_empty = count_q != '0;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 3'd1;
				2'b01:   count_q <= count_q - 3'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// File: rtl/lsrdg_front.sv
// Front end: configuration registers, elevation table, scan position and azimuth.
// Depends on lsrdg_pkg.
module lsrdg_front #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 4096,
	parameter int AZW         = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  lsrdg_pkg::in_item_t                 in_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lsrdg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [17:0]                         cfg_data,
	input  logic [lsrdg_pkg::QCNT_W-1:0]        q_count,
	output logic                                q_push,
	output logic [AZW-1:0]                      q_az,
	output lsrdg_pkg::ray_tag_t                 q_tag
);
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = $clog2(MAX_COLUMNS);

	logic signed [17:0] az_start_q;
	logic [16:0]        az_step_q;
	logic [12:0]        col_count_q;
	logic [6:0]         row_count_q;
	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic signed [15:0] elev_mem [MAX_ROWS];

	logic               valid_s1;
	logic signed [15:0] el_s1;
	logic [5:0]         row_s1;
	logic [11:0]        col_s1;
	logic               end_s1;
	logic [AZW-1:0]     az_s1;

	logic               accept;
	logic               is_ray;
	logic [16:0]        cols_c;
	logic [8:0]         rows_c;
	logic [CW-1:0]      col_last;
	logic [RW-1:0]      row_last;
	logic               col_end;
	logic               row_end;
	logic [AZW-1:0]     az_c;

	assign cfg_ready = 1'b1;
	// hold off while the queue plus the read stage could overflow
	assign full   = (4'(q_count) + 4'(valid_s1)) >= 4'(lsrdg_pkg::QUEUE_DEPTH);
	assign accept = push && !full;
	assign is_ray = in_item.func == lsrdg_pkg::FUNC_RAY;

	always_comb begin
		cols_c = (col_count_q == '0) ? 17'd1 : 17'(col_count_q);
		if (cols_c > 17'(MAX_COLUMNS))
			cols_c = 17'(MAX_COLUMNS);
		rows_c = (row_count_q == '0) ? 9'd1 : 9'(row_count_q);
		if (rows_c > 9'(MAX_ROWS))
			rows_c = 9'(MAX_ROWS);
		col_last = CW'(cols_c - 17'd1);
		row_last = RW'(rows_c - 9'd1);
		col_end  = col_q >= col_last;
		row_end  = row_q >= row_last;
		az_c = AZW'(az_start_q) + AZW'(az_step_q) * AZW'(col_q);
	end

	always_ff @(posedge clk) begin
		if (accept && in_item.func == lsrdg_pkg::FUNC_WRITE
		    && int'(in_item.entry_index) < MAX_ROWS)
			elev_mem[RW'(in_item.entry_index)] <= in_item.elevation_value;
		if (accept && is_ray) begin
			el_s1  <= elev_mem[row_q];
			row_s1 <= 6'(row_q);
			col_s1 <= 12'(col_q);
			end_s1 <= col_end && row_end;
			az_s1  <= az_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_start_q  <= 18'sd0;
			az_step_q   <= 17'd726;
			col_count_q <= 13'd128;
			row_count_q <= 7'd32;
			row_q       <= '0;
			col_q       <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					lsrdg_pkg::CFG_AZ_START:  az_start_q  <= signed'(cfg_data);
					lsrdg_pkg::CFG_AZ_STEP:   az_step_q   <= cfg_data[16:0];
					lsrdg_pkg::CFG_COL_COUNT: col_count_q <= cfg_data[12:0];
					lsrdg_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			valid_s1 <= accept && is_ray;
			if (accept && in_item.func == lsrdg_pkg::FUNC_RESTART) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept && is_ray) begin
				// advance column by column along a row, wrap at the last column and row
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	assign q_push = valid_s1;
	assign q_az   = az_s1;
	assign q_tag  = '{elevation: el_s1, row_number: row_s1, column_number: col_s1,
	                  scan_end: end_s1};
endmodule

// File: rtl/lsrdg_back.sv
// Back end: modulo reduction, two CORDIC rotations, products and result register.
// Depends on lsrdg_pkg.
module lsrdg_back #(
	parameter int AZW          = 31,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic [AZW-1:0]        req_az,
	input  lsrdg_pkg::ray_tag_t   req_tag,
	output logic                  req_pop,
	output logic                  empty,
	input  logic                  pop,
	output lsrdg_pkg::out_item_t  out_item
);
	// a turn is 45 * 2048; ceil(2^30 / 45) gives an exact quotient below 2^24
	localparam logic [24:0] MOD45_RECIP = 25'd23860930;
	localparam logic [23:0] MOD45       = 24'd45;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REDUCE = 3'd1;
	localparam logic [2:0] ST_ROTATE = 3'd2;
	localparam logic [2:0] ST_MULT   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;
	localparam logic [2:0] ST_FOLD   = 3'd5;

	logic [2:0]          state_q;
	logic [AZW-1:0]      red_q;
	logic [48:0]         prod_q;
	logic [4:0]          i_q;
	lsrdg_pkg::ray_tag_t tag_q;
	logic signed [31:0]  xa_q, ya_q, xe_q, ye_q;
	logic signed [25:0]  za_q, ze_q;
	logic                flip_a_q, flip_e_q;
	logic signed [63:0]  px_q, py_q;
	logic signed [31:0]  se_q;
	logic                out_valid_q;
	lsrdg_pkg::out_item_t out_q;

	logic [23:0]         hi_c;
	logic [18:0]         quo_c;
	logic [23:0]         rem_c;
	logic [16:0]         red_c;
	logic [16:0]         el_pos;
	lsrdg_pkg::fold_t    fold_a, fold_e;
	logic signed [25:0]  at;
	logic signed [31:0]  xa_n, ya_n, xe_n, ye_n;
	logic signed [25:0]  za_n, ze_n;
	logic signed [31:0]  ca, sa, ce;
	logic                out_free;

	assign req_pop  = state_q == ST_IDLE && req_valid;
	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign out_item = out_q;

	always_comb begin
		// reduce the part above the low 11 bits modulo 45
		hi_c     = 24'(red_q >> 11);
		quo_c    = prod_q[48:30];
		rem_c    = hi_c - 24'(quo_c) * MOD45;
		red_c    = {rem_c[5:0], red_q[10:0]};
		fold_a   = lsrdg_pkg::fold_angle(red_c);
		el_pos   = req_tag.elevation[15] ? 17'(18'(req_tag.elevation) + lsrdg_pkg::TURN_S)
		                                 : 17'(req_tag.elevation);
		fold_e   = lsrdg_pkg::fold_angle(el_pos);
		at       = 26'(lsrdg_pkg::atan_lut(i_q));
		if (za_q >= 0) begin
			xa_n = xa_q - (ya_q >>> i_q);
			ya_n = ya_q + (xa_q >>> i_q);
			za_n = za_q - at;
		end else begin
			xa_n = xa_q + (ya_q >>> i_q);
			ya_n = ya_q - (xa_q >>> i_q);
			za_n = za_q + at;
		end
		if (ze_q >= 0) begin
			xe_n = xe_q - (ye_q >>> i_q);
			ye_n = ye_q + (xe_q >>> i_q);
			ze_n = ze_q - at;
		end else begin
			xe_n = xe_q + (ye_q >>> i_q);
			ye_n = ye_q - (xe_q >>> i_q);
			ze_n = ze_q + at;
		end
		ca = flip_a_q ? -xa_q : xa_q;
		sa = flip_a_q ? -ya_q : ya_q;
		ce = flip_e_q ? -xe_q : xe_q;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				// offset by two turns so the value is never negative
				red_q    <= req_az + AZW'(2 * lsrdg_pkg::TURN);
				tag_q    <= req_tag;
				xe_q     <= lsrdg_pkg::CORDIC_GAIN;
				ye_q     <= 32'sd0;
				ze_q     <= fold_e.z;
				flip_e_q <= fold_e.flip;
			end
			ST_REDUCE: begin
				prod_q <= 49'(hi_c) * 49'(MOD45_RECIP);
			end
			ST_FOLD: begin
				i_q      <= 5'd0;
				xa_q     <= lsrdg_pkg::CORDIC_GAIN;
				ya_q     <= 32'sd0;
				za_q     <= fold_a.z;
				flip_a_q <= fold_a.flip;
			end
			ST_ROTATE: begin
				xa_q <= xa_n;
				ya_q <= ya_n;
				za_q <= za_n;
				xe_q <= xe_n;
				ye_q <= ye_n;
				ze_q <= ze_n;
				i_q  <= i_q + 5'd1;
			end
			ST_MULT: begin
				px_q <= 64'(ce) * 64'(ca);
				py_q <= 64'(ce) * 64'(sa);
				se_q <= flip_e_q ? -ye_q : ye_q;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.dir_x         <= lsrdg_pkg::round_q45(px_q);
					out_q.dir_y         <= lsrdg_pkg::round_q45(py_q);
					out_q.dir_z         <= lsrdg_pkg::round_q15(se_q);
					out_q.row_number    <= tag_q.row_number;
					out_q.column_number <= tag_q.column_number;
					out_q.scan_end      <= tag_q.scan_end;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (req_valid) state_q <= ST_REDUCE;
				ST_REDUCE: state_q <= ST_FOLD;
				ST_FOLD:   state_q <= ST_ROTATE;
				ST_ROTATE: if (i_q == 5'(CORDIC_STEPS - 1)) state_q <= ST_MULT;
				ST_MULT:   state_q <= ST_DONE;
				ST_DONE:   if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end
endmodule

// File: rtl/lsrdg_checker.sv
// Port-level checks of the lidar ray direction generator, bound to the top level.
// Depends on lsrdg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsrdg_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input lsrdg_pkg::out_item_t out_item
);
	`LSRDG_ASSERT_NR(a_reset_empty, clk, !arst_n |-> empty, "result visible during reset")
	`LSRDG_ASSERT(a_hold, clk, arst_n, !empty && !pop |=> !empty && $stable(out_item), "waiting result changed")
	`LSRDG_ASSERT(a_sat, clk, arst_n, empty || (out_item.dir_x != 16'h8000 && out_item.dir_y != 16'h8000 && out_item.dir_z != 16'h8000), "direction not saturated")
endmodule

bind lidar_scan_ray_direction_generator lsrdg_checker u_lsrdg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.out_item(out_item)
);
